/* rtl/ctf_pkg.sv */
// Shared types, constants and helper functions for the complementary tilt filter.
package ctf_pkg;

  localparam int CAL_SAMPLES_DEF  = 512;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int SUM_W   = 25;
  localparam int ANGLE_W = 26;
  localparam int Z_W     = 27;
  localparam int NUM_W   = 49;
  localparam int DEN_W   = 18;
  localparam int MIX_W   = 54;

  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [16:0] WEIGHT_RESET = 17'd64225;
  localparam logic [DEN_W-1:0] GYRO_DIV = 18'd131000;
  localparam logic [15:0] GYRO_BIAS     = 16'd65500;
  localparam logic signed [16:0] ONE_G  = 17'sd16384;

  localparam logic [0:0] REG_GYRO_WEIGHT = 1'b0;

  typedef struct packed {
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic [15:0]        elapsed_ms;
  } in_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] tilt_angle;
    logic                      calibrating;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic signed [17:0] y;
    logic signed [17:0] x;
  } crd_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVY, S_DIVY_W, S_DIVZ, S_DIVZ_W, S_DIVG, S_DIVG_W,
    S_GMUL, S_GDIV, S_GDIV_W, S_CRD, S_CRD_W, S_MIX, S_DONE
  } state_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117305;
      5'd6:  v = 27'sd58666;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [MIX_W-1:0] v);
    logic signed [ANGLE_W-1:0] r;
    if (v > MIX_W'(33554431)) r = 26'sh1FFFFFF;
    else if (v < -MIX_W'(33554432)) r = 26'sh2000000;
    else r = v[ANGLE_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/ctf_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module ctf_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctf_pkg::div_req_t         req,
  output logic                      done,
  output logic [ctf_pkg::NUM_W-1:0] quo
);
  import ctf_pkg::*;

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;

  always_comb begin
    rem_sh = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= qbit ? (rem_sh - {1'b0, den_r}) : rem_sh;
        num_r <= {num_r[NUM_W-2:0], qbit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

/* rtl/ctf_cordic.sv */
// Iterative vectoring CORDIC, atan2 in Q16 degrees, one rotation per cycle.
module ctf_cordic #(
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ctf_pkg::crd_req_t              req,
  output logic                           done,
  output logic signed [ctf_pkg::Z_W-1:0] z
);
  import ctf_pkg::*;

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic signed [29:0]    x_r, y_r;
  logic signed [Z_W-1:0] z_r;
  logic [IW-1:0]         i_r;
  logic                  busy_r;
  logic                  done_r;
  logic signed [29:0]    x_sh, y_sh, x_in, y_in;

  always_comb begin
    x_sh = x_r >>> i_r;
    y_sh = y_r >>> i_r;
    x_in = {{4{req.x[17]}}, req.x, 8'd0};
    y_in = {{4{req.y[17]}}, req.y, 8'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        i_r <= '0;
        if (req.x == 18'sd0 && req.y == 18'sd0) begin
          z_r    <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (req.x < 0) begin
            // left half plane: half turn first
            x_r <= -x_in;
            y_r <= -y_in;
            z_r <= (req.y >= 0) ? 27'sd11796480 : -27'sd11796480;
          end else begin
            x_r <= x_in;
            y_r <= y_in;
            z_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (y_r >= 0) begin
          x_r <= x_r + y_sh;
          y_r <= y_r - x_sh;
          z_r <= z_r + atan_q16(5'(i_r));
        end else begin
          x_r <= x_r - y_sh;
          y_r <= y_r + x_sh;
          z_r <= z_r - atan_q16(5'(i_r));
        end
        i_r <= i_r + 1'b1;
        if (i_r == IW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign z    = z_r;

endmodule

/* rtl/complementary_tilt_filter_top.sv */
// Top level: sequencer, calibration, gyro step and serial weighted mix.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_ready  | in_data  (ctf_pkg::in_t)
//  out_    | output    | out_valid/out_ready| out_data (ctf_pkg::out_t)
//  cfg_    | input     | APB, pready high   | gyro_weight at byte address 0
//
// An early calibration transaction accumulates its samples and goes straight
// to the output. The last one runs three divisions (offsets) and the CORDIC.
// A filtered transaction runs a serial gyro product, a serial divide by
// 131000, the CORDIC and a serial weighted mix. The divider, at one quotient
// bit per cycle, makes up most of a filtered transaction.
// Reset is synchronous active low; it clears counters, sums, offsets and the
// angle, and reloads the weight register with its default. A new transaction
// is taken once the previous one has been moved to the output register, even
// if that result is stalled.
module complementary_tilt_filter_top #(
  parameter int CAL_SAMPLES  = ctf_pkg::CAL_SAMPLES_DEF,
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ctf_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ctf_pkg::out_t  out_data,
  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [2:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready
);
  import ctf_pkg::*;

  localparam int CW = $clog2(CAL_SAMPLES + 1);

  state_t state_r, state_nxt;

  // config
  logic [16:0] gyro_weight_r;

  // calibration state
  logic [CW-1:0]            count_r;
  logic signed [SUM_W-1:0]  sum_y_r, sum_z_r, sum_g_r;
  logic signed [15:0]       off_y_r, off_g_r;
  logic signed [16:0]       off_z_r;
  logic signed [ANGLE_W-1:0] angle_r;

  // per-transaction work registers
  in_t                 in_r;
  logic                cal_r;
  logic                neg_r;
  logic [32:0]         mcand_r, pacc_r;
  logic [15:0]         dts_r;
  logic [4:0]          cnt_r;
  logic signed [33:0]  step_r;
  logic signed [MIX_W-1:0] ma_r, mb_r, macc_r;
  logic [16:0]         ws_r, was_r;

  logic                out_valid_r;
  out_t                out_data_r;

  // unit links
  div_req_t              div_req;
  logic                  div_done;
  logic [NUM_W-1:0]      div_quo;
  crd_req_t              crd_req;
  logic                  crd_done;
  logic signed [Z_W-1:0] crd_z;

  logic                  accept;
  logic                  out_load;
  logic                  last_cal;
  logic signed [16:0]    d_in;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]      sum_mag;
  logic signed [SUM_W-1:0] q_signed;
  logic [16:0]           w_clamp;
  logic signed [MIX_W-1:0] mix_nxt;
  logic signed [MIX_W-1:0] mix_rnd;

  ctf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  ctf_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (crd_req),
    .done (crd_done),
    .z    (crd_z)
  );

  // ---------------------------------------------------------------- helpers
  always_comb begin
    accept   = in_valid && in_ready;
    out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);
    last_cal = (count_r == CW'(CAL_SAMPLES - 1));
    d_in     = 17'(in_data.gyro_x) - 17'(off_g_r);
    w_clamp  = (gyro_weight_r > WEIGHT_ONE) ? WEIGHT_ONE : gyro_weight_r;

    // offset division operand: truncation toward zero through sign/magnitude
    case (state_r)
      S_DIVZ, S_DIVZ_W: sum_sel = sum_z_r;
      S_DIVG, S_DIVG_W: sum_sel = sum_g_r;
      default:          sum_sel = sum_y_r;
    endcase
    sum_mag  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    q_signed = sum_sel[SUM_W-1] ? -SUM_W'(div_quo) : SUM_W'(div_quo);

    // one partial-product step per weight bit
    mix_nxt = macc_r + (ws_r[0] ? ma_r : '0) + (was_r[0] ? mb_r : '0);
    mix_rnd = (mix_nxt + MIX_W'(32768)) >>> 16;
  end

  // ---------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (count_r < CW'(CAL_SAMPLES)) state_nxt = last_cal ? S_DIVY : S_DONE;
          else state_nxt = S_GMUL;
        end
      end
      S_DIVY:   state_nxt = S_DIVY_W;
      S_DIVY_W: if (div_done) state_nxt = S_DIVZ;
      S_DIVZ:   state_nxt = S_DIVZ_W;
      S_DIVZ_W: if (div_done) state_nxt = S_DIVG;
      S_DIVG:   state_nxt = S_DIVG_W;
      S_DIVG_W: if (div_done) state_nxt = S_CRD;
      S_GMUL:   if (cnt_r == 5'd15) state_nxt = S_GDIV;
      S_GDIV:   state_nxt = S_GDIV_W;
      S_GDIV_W: if (div_done) state_nxt = S_CRD;
      S_CRD:    state_nxt = S_CRD_W;
      S_CRD_W:  if (crd_done) state_nxt = cal_r ? S_DONE : S_MIX;
      S_MIX:    if (cnt_r == 5'd16) state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------- unit controls
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    div_req.start = 1'b0;
    div_req.num   = NUM_W'(sum_mag);
    div_req.den   = DEN_W'(CAL_SAMPLES);
    crd_req.start = (state_r == S_CRD);
    crd_req.y     = 18'(in_r.accel_y) - 18'(off_y_r);
    crd_req.x     = 18'(in_r.accel_z) - 18'(off_z_r);
    unique case (state_r)
      S_DIVY, S_DIVZ, S_DIVG: div_req.start = 1'b1;
      S_GDIV: begin
        div_req.start = 1'b1;
        div_req.num   = {pacc_r, 16'd0} + NUM_W'(GYRO_BIAS);
        div_req.den   = GYRO_DIV;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------- config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_weight_r <= WEIGHT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == REG_GYRO_WEIGHT) begin
      gyro_weight_r <= cfg_pwdata[16:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_GYRO_WEIGHT) ? {15'd0, gyro_weight_r} : 32'd0;

  // ---------------------------------------------------------- filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      sum_g_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      off_g_r <= '0;
      angle_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept && count_r < CW'(CAL_SAMPLES)) begin
            sum_y_r <= sum_y_r + SUM_W'(in_data.accel_y);
            sum_z_r <= sum_z_r + SUM_W'(in_data.accel_z);
            sum_g_r <= sum_g_r + SUM_W'(in_data.gyro_x);
            count_r <= count_r + 1'b1;
          end
        end
        S_DIVY_W: if (div_done) off_y_r <= q_signed[15:0];
        S_DIVZ_W: if (div_done) off_z_r <= q_signed[16:0] - ONE_G;
        S_DIVG_W: if (div_done) off_g_r <= q_signed[15:0];
        S_CRD_W:  if (crd_done && cal_r) angle_r <= sat_angle(MIX_W'(crd_z));
        S_MIX:    if (cnt_r == 5'd16) angle_r <= sat_angle(mix_rnd);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- work registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          in_r    <= in_data;
          cal_r   <= (count_r < CW'(CAL_SAMPLES));
          neg_r   <= d_in[16];
          mcand_r <= d_in[16] ? 33'(-d_in) : 33'(d_in);
          pacc_r  <= '0;
          dts_r   <= in_data.elapsed_ms;
          cnt_r   <= '0;
        end
      end
      S_GMUL: begin
        if (dts_r[0]) pacc_r <= pacc_r + mcand_r;
        mcand_r <= {mcand_r[31:0], 1'b0};
        dts_r   <= {1'b0, dts_r[15:1]};
        cnt_r   <= cnt_r + 5'd1;
      end
      S_GDIV_W: begin
        if (div_done) step_r <= neg_r ? -34'(div_quo) : 34'(div_quo);
      end
      S_CRD_W: begin
        if (crd_done) begin
          ma_r   <= MIX_W'(angle_r) + MIX_W'(step_r);
          mb_r   <= MIX_W'(crd_z);
          ws_r   <= w_clamp;
          was_r  <= WEIGHT_ONE - w_clamp;
          macc_r <= '0;
          cnt_r  <= '0;
        end
      end
      S_MIX: begin
        macc_r <= mix_nxt;
        ma_r   <= ma_r <<< 1;
        mb_r   <= mb_r <<< 1;
        ws_r   <= {1'b0, ws_r[16:1]};
        was_r  <= {1'b0, was_r[16:1]};
        cnt_r  <= cnt_r + 5'd1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.tilt_angle  <= angle_r;
      out_data_r.calibrating <= cal_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------- assertions
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVY_W || state_r == S_DIVZ_W ||
                  state_r == S_DIVG_W || state_r == S_GDIV_W))
    else $error("divider finished outside a wait state");

  a_crd_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    crd_done |-> state_r == S_CRD_W)
    else $error("cordic finished outside its wait state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAL_SAMPLES))
    else $error("calibration count overran");

  a_filtered_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.calibrating) |-> count_r == CW'(CAL_SAMPLES))
    else $error("filtered result before calibration finished");

endmodule
